[design/ebv_pkg.sv]
// Shared constants, types and functions for the Euler box vertex rotate block.
// Holds the quarter-wave sine table (built at elaboration) and the rounding helper.
// No dependencies.
`default_nettype none
package ebv_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int TABLE_BITS = 10;
  localparam int TAB_N      = 1 << TABLE_BITS;

  localparam int ANG_W  = 14;
  localparam int OUT_W  = 16;
  localparam int CIDX_W = 3;
  localparam int NCORNER = 8;

  localparam int QUARTER = 1440;
  localparam int FULL    = 4 * QUARTER;
  localparam int REM_W   = 11;
  localparam int RED_W   = 15;

  localparam int ROM_W  = FRAC_BITS + 1;
  localparam int SIN_W  = FRAC_BITS + 2;
  localparam int IDX_W  = TABLE_BITS + 1;
  localparam int PROD_W = 2 * SIN_W + 1;
  localparam int RND_W  = PROD_W + 1 - FRAC_BITS;
  localparam int MAT_W  = FRAC_BITS + 3;
  localparam int SUM_W  = MAT_W + 2;

  // index = floor((rem * 2^TABLE_BITS + QUARTER/2) / QUARTER) via reciprocal
  localparam int V_W    = REM_W + TABLE_BITS;
  localparam int RCP_SH = V_W + 11;
  localparam int RCP_W  = RCP_SH - 9;
  localparam longint unsigned RCP_M =
    ((64'd1 << RCP_SH) + QUARTER - 1) / QUARTER;

  localparam longint unsigned PIH_Q30 = 64'd1686629713;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [1:0]       quad;
    logic [REM_W-1:0] rem;
  } ang_cls_t;

  typedef struct packed {
    ang_cls_t ax;
    ang_cls_t ay;
    ang_cls_t az;
  } item_cls_t;

  typedef logic signed [MAT_W-1:0] ent_t;
  typedef ent_t [2:0][2:0] mat_t;

  typedef logic [ROM_W-1:0] sine_rom_t [0:TAB_N];

  // per corner: {neg x, neg y, neg z}
  typedef logic [2:0] corner_neg_t [0:NCORNER-1];
  localparam corner_neg_t CORNER_NEG = '{
    3'b000, 3'b001, 3'b101, 3'b100, 3'b010, 3'b011, 3'b111, 3'b110
  };

  // shift-subtract division, used only while building the table
  function automatic u64_t udiv64(input u64_t num, input u64_t den);
    u64_t q;
    u64_t r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series of sin in Q30 up to x^21, truncating steps
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    u64_t      x;
    u64_t      term;
    longint    sum;
    for (int k = 0; k <= TAB_N; k++) begin
      x = (u64_t'(k) * PIH_Q30 + u64_t'(TAB_N / 2)) >> TABLE_BITS;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = udiv64(term, u64_t'((2 * n) * (2 * n + 1)));
        if (n[0]) sum = sum - longint'(term);
        else      sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      rom[k] = ROM_W'((u64_t'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // add half, then floor shift
  function automatic logic signed [RND_W-1:0] rnd_q(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] t;
    t = (PROD_W+1)'(p) + $signed((PROD_W+1)'(64'd1 << (FRAC_BITS - 1)));
    return RND_W'(t >>> FRAC_BITS);
  endfunction

endpackage
`default_nettype wire

[design/ebv_front.sv]
// Front end: accepts angle triples, reduces each angle to quadrant and remainder,
// and queues the classified items (two entries). Uses ebv_pkg.
`default_nettype none
module ebv_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output      logic                      busy,
  input  wire logic [ebv_pkg::ANG_W-1:0] in_angle_x,
  input  wire logic [ebv_pkg::ANG_W-1:0] in_angle_y,
  input  wire logic [ebv_pkg::ANG_W-1:0] in_angle_z,
  output      logic                      q_valid,
  output      ebv_pkg::item_cls_t        q_item,
  input  wire logic                      q_pop
);
  import ebv_pkg::*;

  item_cls_t  fifo_r [0:1];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_cls_t  cls;

  function automatic ang_cls_t classify(input logic [ANG_W-1:0] a);
    logic [RED_W-1:0] t;
    ang_cls_t         c;
    // offset by two turns so the value is non-negative
    t = RED_W'($signed({{(RED_W-ANG_W){a[ANG_W-1]}}, a}) + $signed(RED_W'(2 * FULL)));
    if (t >= RED_W'(3 * FULL))      t = t - RED_W'(3 * FULL);
    else if (t >= RED_W'(2 * FULL)) t = t - RED_W'(2 * FULL);
    else if (t >= RED_W'(FULL))     t = t - RED_W'(FULL);
    if (t >= RED_W'(3 * QUARTER)) begin
      c.quad = 2'd3;
      t = t - RED_W'(3 * QUARTER);
    end else if (t >= RED_W'(2 * QUARTER)) begin
      c.quad = 2'd2;
      t = t - RED_W'(2 * QUARTER);
    end else if (t >= RED_W'(QUARTER)) begin
      c.quad = 2'd1;
      t = t - RED_W'(QUARTER);
    end else begin
      c.quad = 2'd0;
    end
    c.rem = REM_W'(t);
    return c;
  endfunction

  always_comb begin
    cls.ax = classify(in_angle_x);
    cls.ay = classify(in_angle_y);
    cls.az = classify(in_angle_z);
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= cls;
  end

endmodule
`default_nettype wire

[design/ebv_calc.sv]
// Back end, matrix part: table lookups of sin/cos per axis, then Ry*Rx and
// Rz*(Ry*Rx) with one rounding per entry. Eight-step sequencer. Uses ebv_pkg.
`default_nettype none
module ebv_calc (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire ebv_pkg::item_cls_t q_item,
  output      logic               q_pop,
  output      logic               mat_valid,
  output      ebv_pkg::mat_t      mat,
  input  wire logic               mat_ready
);
  import ebv_pkg::*;

  localparam logic [2:0] STEP_LAST = 3'd7;

  logic                     active_r;
  logic [2:0]               step_r;
  item_cls_t                item_r;
  logic [IDX_W-1:0]         sidx_r, cidx_r;
  logic                     sneg_r, cneg_r;
  logic signed [SIN_W-1:0]  sin_r [0:2];
  logic signed [SIN_W-1:0]  cos_r [0:2];
  logic signed [SIN_W-1:0]  yx_r  [0:2][0:2];
  mat_t                     m_r;

  ang_cls_t                 cur;
  logic [V_W-1:0]           v;
  logic [V_W+RCP_W-1:0]     prod;
  logic [IDX_W-1:0]         base;
  logic [1:0]               cquad;
  logic signed [SIN_W-1:0]  sraw, craw;
  logic [1:0]               wsel;

  function automatic logic signed [PROD_W-1:0] mac2(
    input logic signed [SIN_W-1:0] a, input logic signed [SIN_W-1:0] b,
    input logic signed [SIN_W-1:0] c, input logic signed [SIN_W-1:0] d,
    input logic                    sub);
    logic signed [PROD_W-1:0] p1, p2;
    p1 = PROD_W'(a) * PROD_W'(b);
    p2 = PROD_W'(c) * PROD_W'(d);
    return sub ? (p1 - p2) : (p1 + p2);
  endfunction

  assign mat_valid = active_r && (step_r == STEP_LAST);
  assign mat       = m_r;
  assign q_pop     = q_valid && (!active_r || (mat_valid && mat_ready));

  // axis selected by step
  always_comb begin
    case (step_r)
      3'd0:    cur = item_r.ax;
      3'd1:    cur = item_r.ay;
      3'd2:    cur = item_r.az;
      default: cur = item_r.ax;
    endcase
    v     = {cur.rem, {TABLE_BITS{1'b0}}} + V_W'(QUARTER / 2);
    prod  = (V_W+RCP_W)'(v) * (V_W+RCP_W)'(RCP_M);
    base  = IDX_W'(prod >> RCP_SH);
    cquad = cur.quad + 2'd1;
    sraw  = $signed({1'b0, SINE_ROM[sidx_r]});
    craw  = $signed({1'b0, SINE_ROM[cidx_r]});
    wsel  = 2'(step_r - 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= 3'd0;
    end else if (q_pop) begin
      active_r <= 1'b1;
      step_r   <= 3'd0;
    end else if (active_r) begin
      if (step_r != STEP_LAST) step_r <= step_r + 3'd1;
      else if (mat_ready)      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_item;
    if (active_r && step_r <= 3'd2) begin
      sidx_r <= cur.quad[0] ? (IDX_W'(TAB_N) - base) : base;
      cidx_r <= cur.quad[0] ? base : (IDX_W'(TAB_N) - base);
      sneg_r <= cur.quad[1];
      cneg_r <= cquad[1];
    end
    // registered table read, one axis a step
    if (active_r && step_r >= 3'd1 && step_r <= 3'd3) begin
      sin_r[wsel] <= sneg_r ? -sraw : sraw;
      cos_r[wsel] <= cneg_r ? -craw : craw;
    end
    if (active_r && step_r == 3'd4) begin
      yx_r[0][0] <= cos_r[1];
      yx_r[0][1] <= SIN_W'(rnd_q(mac2(sin_r[1], sin_r[0], '0, '0, 1'b0)));
      yx_r[0][2] <= SIN_W'(rnd_q(mac2(sin_r[1], cos_r[0], '0, '0, 1'b0)));
      yx_r[1][0] <= '0;
      yx_r[1][1] <= cos_r[0];
      yx_r[1][2] <= -sin_r[0];
      yx_r[2][0] <= -sin_r[1];
      yx_r[2][1] <= SIN_W'(rnd_q(mac2(cos_r[1], sin_r[0], '0, '0, 1'b0)));
      yx_r[2][2] <= SIN_W'(rnd_q(mac2(cos_r[1], cos_r[0], '0, '0, 1'b0)));
    end
    if (active_r && step_r == 3'd5) begin
      for (int j = 0; j < 3; j++) begin
        m_r[0][j] <= MAT_W'(rnd_q(mac2(cos_r[2], yx_r[0][j], sin_r[2], yx_r[1][j], 1'b1)));
      end
    end
    if (active_r && step_r == 3'd6) begin
      for (int j = 0; j < 3; j++) begin
        m_r[1][j] <= MAT_W'(rnd_q(mac2(sin_r[2], yx_r[0][j], cos_r[2], yx_r[1][j], 1'b0)));
        m_r[2][j] <= MAT_W'(yx_r[2][j]);
      end
    end
  end

endmodule
`default_nettype wire

[design/ebv_emit.sv]
// Back end, output part: holds one rotation matrix and emits the eight cube
// corners, one a cycle, as signed sums of matrix entries, saturated. Uses ebv_pkg.
`default_nettype none
module ebv_emit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       mat_valid,
  input  wire ebv_pkg::mat_t              mat,
  output      logic                       mat_ready,
  output      logic                       out_valid,
  output      logic [ebv_pkg::CIDX_W-1:0] out_corner_index,
  output      logic [ebv_pkg::OUT_W-1:0]  out_vert_x,
  output      logic [ebv_pkg::OUT_W-1:0]  out_vert_y,
  output      logic [ebv_pkg::OUT_W-1:0]  out_vert_z,
  output      logic                       out_last_corner
);
  import ebv_pkg::*;

  localparam int CMP_W = ((SUM_W > OUT_W) ? SUM_W : OUT_W) + 1;
  localparam logic [CIDX_W-1:0] CNT_LAST = CIDX_W'(NCORNER - 1);

  logic                    active_r;
  logic [CIDX_W-1:0]       cnt_r;
  mat_t                    mat_r;
  logic                    out_valid_r;
  logic [CIDX_W-1:0]       out_idx_r;
  logic [OUT_W-1:0]        out_v_r [0:2];
  logic                    out_last_r;
  logic [OUT_W-1:0]        vert [0:2];
  logic                    load;

  function automatic logic [OUT_W-1:0] sat(input logic signed [SUM_W-1:0] s);
    logic signed [CMP_W-1:0] e;
    e = CMP_W'(s);
    if (e > $signed(CMP_W'((1 << (OUT_W - 1)) - 1)))  return {1'b0, {(OUT_W-1){1'b1}}};
    else if (e < -$signed(CMP_W'(1 << (OUT_W - 1))))  return {1'b1, {(OUT_W-1){1'b0}}};
    else                                               return OUT_W'(e);
  endfunction

  assign mat_ready = !active_r || (cnt_r == CNT_LAST);
  assign load      = mat_valid && mat_ready;

  always_comb begin
    logic signed [SUM_W-1:0] s;
    logic [2:0]              neg;
    neg = CORNER_NEG[cnt_r];
    for (int i = 0; i < 3; i++) begin
      s = '0;
      for (int j = 0; j < 3; j++) begin
        if (neg[2-j]) s = s - SUM_W'(mat_r[i][j]);
        else          s = s + SUM_W'(mat_r[i][j]);
      end
      vert[i] = sat(s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= active_r;
      if (load) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) mat_r <= mat;
    out_idx_r  <= cnt_r;
    out_last_r <= (cnt_r == CNT_LAST);
    for (int i = 0; i < 3; i++) out_v_r[i] <= vert[i];
  end

  assign out_valid        = out_valid_r;
  assign out_corner_index = out_idx_r;
  assign out_vert_x       = out_v_r[0];
  assign out_vert_y       = out_v_r[1];
  assign out_vert_z       = out_v_r[2];
  assign out_last_corner  = out_last_r;

endmodule
`default_nettype wire

[design/euler_box_vertex_rotate_core.sv]
// Top level of the Euler box vertex rotate block: front end, queue, matrix
// sequencer and corner emitter. Uses ebv_pkg, ebv_front, ebv_calc, ebv_emit.
//
// An angle triple is taken when start is high and busy low; each one yields
// eight corner results on out_* in consecutive cycles, strobed by out_valid,
// with out_last_corner on the eighth. The receiver cannot stall. The
// eight-step matrix sequencer runs one item ahead of the eight-corner emitter,
// so the matrix of an item is built while the corners of the one before it go
// out. A two-entry queue lets start be taken while earlier items are still in
// work; busy rises only when it is full.
`default_nettype none
module euler_box_vertex_rotate_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output      logic                       busy,
  input  wire logic [ebv_pkg::ANG_W-1:0]  in_angle_x,
  input  wire logic [ebv_pkg::ANG_W-1:0]  in_angle_y,
  input  wire logic [ebv_pkg::ANG_W-1:0]  in_angle_z,
  output      logic                       out_valid,
  output      logic [ebv_pkg::CIDX_W-1:0] out_corner_index,
  output      logic [ebv_pkg::OUT_W-1:0]  out_vert_x,
  output      logic [ebv_pkg::OUT_W-1:0]  out_vert_y,
  output      logic [ebv_pkg::OUT_W-1:0]  out_vert_z,
  output      logic                       out_last_corner
);
  import ebv_pkg::*;

  logic      q_valid;
  item_cls_t q_item;
  logic      q_pop;
  logic      mat_valid;
  mat_t      mat;
  logic      mat_ready;

  ebv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_angle_x (in_angle_x),
    .in_angle_y (in_angle_y),
    .in_angle_z (in_angle_z),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  ebv_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .mat_valid (mat_valid),
    .mat       (mat),
    .mat_ready (mat_ready)
  );

  ebv_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .mat_valid        (mat_valid),
    .mat              (mat),
    .mat_ready        (mat_ready),
    .out_valid        (out_valid),
    .out_corner_index (out_corner_index),
    .out_vert_x       (out_vert_x),
    .out_vert_y       (out_vert_y),
    .out_vert_z       (out_vert_z),
    .out_last_corner  (out_last_corner)
  );

endmodule
`default_nettype wire
